FILE: sv/nrbs_pkg.sv
// Shared types and constants for the nibble RAM bus slave.
package nrbs_pkg;

   localparam int REGISTER_COUNT = 4;
   localparam int MAIN_CHARS     = 16;
   localparam int STATUS_CHARS   = 4;

   localparam int REG_W       = $clog2(REGISTER_COUNT);
   localparam int MAIN_CHAR_W = $clog2(MAIN_CHARS);
   localparam int STAT_CHAR_W = $clog2(STATUS_CHARS);
   localparam int MAIN_AW     = REG_W + MAIN_CHAR_W;
   localparam int STAT_AW     = REG_W + STAT_CHAR_W;
   localparam int MAIN_DEPTH  = REGISTER_COUNT * MAIN_CHARS;
   localparam int STAT_DEPTH  = REGISTER_COUNT * STATUS_CHARS;

   localparam logic [3:0] PHASE_MAX   = 4'd9;
   localparam logic [3:0] PH_OPR      = 4'd3;
   localparam logic [3:0] PH_OPA      = 4'd4;
   localparam logic [3:0] PH_READ     = 4'd6;
   localparam logic [3:0] PH_WRITE    = 4'd7;
   localparam logic [3:0] PH_CHAR     = 4'd8;

   localparam logic [7:0] SRC_MASK = 8'hF1;
   localparam logic [7:0] SRC_CODE = 8'h21;
   localparam logic [7:0] OP_RDM   = 8'hE9;
   localparam logic [7:0] OP_SBM   = 8'hE8;
   localparam logic [7:0] OP_ADM   = 8'hEB;
   localparam logic [7:0] OP_RD0   = 8'hEC;
   localparam logic [7:0] OP_RD3   = 8'hEF;
   localparam logic [7:0] OP_WRM   = 8'hE0;
   localparam logic [7:0] OP_WMP   = 8'hE1;
   localparam logic [7:0] OP_WR0   = 8'hE4;
   localparam logic [7:0] OP_WR3   = 8'hE7;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_SYNC  = 2'd1,
      MODE_RESET = 2'd2
   } mode_type;

   typedef struct packed {
      logic               clear;
      logic               main_we;
      logic               status_we;
      logic [3:0]         wr_data;
      logic [MAIN_AW-1:0] main_addr_in;
      logic [STAT_AW-1:0] status_addr_in;
   } store_ctl_type;

   typedef struct packed {
      logic       drive_enable;
      logic [3:0] drive_value;
      logic [3:0] port_value;
   } rsp_word_type;

endpackage

FILE: sv/nibble_ram_bus_slave_4002.sv
// Top level of the nibble RAM bus slave: bus phase sequencer and response queue.
//
// The block takes one event word per clock while req_ready is high (phase tick,
// SYNC edge or RESET-pin edge) and returns one response word for each, carrying
// the bus drive state and the output port. A response appears in the cycle after
// its request is taken and waits in a two-word queue, so requests keep flowing
// while the response side stalls until that queue is full. The RAM nibbles live
// in two synchronous memories that are read every cycle at the address the next
// state selects, so the read data is ready when the following event arrives; a
// write feeds straight through to a read of the same entry. Per-entry valid
// bits make reset and the RESET pin clear both memories at once, with no
// clearing pass. The chip pair register may be written at any idle time and
// takes effect on the next event.
module nibble_ram_bus_slave_4002 (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_mode,
   input  logic [3:0] req_bus_nibble,
   input  logic       req_chip_match,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_bus_drive_enable,
   output logic [3:0] rsp_bus_drive_value,
   output logic [3:0] rsp_port_value
);

   localparam int REG_W = nrbs_pkg::REG_W;

   logic [1:0]       chip_pair_ff;
   logic             seen_sync_ff, seen_sync_in;
   logic [3:0]       phase_ff, phase_in;
   logic [7:0]       opcode_ff, opcode_in;
   logic             sel_ff, sel_in;
   logic [REG_W-1:0] reg_ff, reg_in;
   logic [3:0]       char_ff, char_in;
   logic [3:0]       port_ff, port_in;
   logic             drv_ff, drv_in;
   logic [3:0]       drv_val_ff, drv_val_in;

   nrbs_pkg::store_ctl_type ctl;
   logic [3:0]              main_data;
   logic [3:0]              status_data;

   nrbs_pkg::rsp_word_type rsp_q_ff [2];
   nrbs_pkg::rsp_word_type rsp_word;
   logic                   wr_ptr_ff, rd_ptr_ff;
   logic [1:0]             count_ff;
   logic                   push, pop;
   logic                   is_src;

   assign req_ready = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign push      = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign is_src    = ((opcode_ff & nrbs_pkg::SRC_MASK) == nrbs_pkg::SRC_CODE);

   always_comb begin
      seen_sync_in = seen_sync_ff;
      phase_in     = phase_ff;
      opcode_in    = opcode_ff;
      sel_in       = sel_ff;
      reg_in       = reg_ff;
      char_in      = char_ff;
      port_in      = port_ff;
      drv_in       = drv_ff;
      drv_val_in   = drv_val_ff;
      ctl.clear     = 1'b0;
      ctl.main_we   = 1'b0;
      ctl.status_we = 1'b0;
      ctl.wr_data   = req_bus_nibble;
      if (push) begin
         case (req_mode)
            nrbs_pkg::MODE_TICK: begin
               if (seen_sync_ff) begin
                  if (phase_ff < nrbs_pkg::PHASE_MAX) phase_in = phase_ff + 4'd1;
                  case (phase_in)
                     nrbs_pkg::PH_OPR: opcode_in = {req_bus_nibble, 4'd0};
                     nrbs_pkg::PH_OPA: opcode_in = {opcode_ff[7:4], req_bus_nibble};
                     nrbs_pkg::PH_READ: begin
                        if (sel_ff) begin
                           case (opcode_ff) inside
                              nrbs_pkg::OP_RDM, nrbs_pkg::OP_SBM, nrbs_pkg::OP_ADM: begin
                                 drv_in     = 1'b1;
                                 drv_val_in = main_data;
                              end
                              [nrbs_pkg::OP_RD0:nrbs_pkg::OP_RD3]: begin
                                 drv_in     = 1'b1;
                                 drv_val_in = status_data;
                              end
                              default: ;
                           endcase
                        end
                     end
                     nrbs_pkg::PH_WRITE: begin
                        if (is_src) begin
                           if (req_chip_match) begin
                              sel_in = (req_bus_nibble[3:2] == chip_pair_ff);
                              if (sel_in) reg_in = req_bus_nibble[REG_W-1:0];
                           end
                        end else if (sel_ff && req_chip_match) begin
                           case (opcode_ff) inside
                              nrbs_pkg::OP_WRM: ctl.main_we = 1'b1;
                              nrbs_pkg::OP_WMP: port_in = req_bus_nibble;
                              [nrbs_pkg::OP_WR0:nrbs_pkg::OP_WR3]: ctl.status_we = 1'b1;
                              default: ;
                           endcase
                        end
                        drv_in = 1'b0;
                     end
                     nrbs_pkg::PH_CHAR: begin
                        if (sel_ff && is_src) char_in = req_bus_nibble;
                     end
                     default: ;
                  endcase
               end
            end
            nrbs_pkg::MODE_SYNC: begin
               seen_sync_in = 1'b1;
               phase_in     = 4'd0;
               opcode_in    = 8'd0;
            end
            nrbs_pkg::MODE_RESET: begin
               ctl.clear    = 1'b1;
               seen_sync_in = 1'b0;
               phase_in     = 4'd0;
               opcode_in    = 8'd0;
               sel_in       = 1'b0;
               reg_in       = '0;
               char_in      = 4'd0;
               port_in      = 4'd0;
               drv_in       = 1'b0;
            end
            default: ;
         endcase
      end
      ctl.main_addr_in   = {reg_in, char_in};
      ctl.status_addr_in = {reg_in, opcode_in[nrbs_pkg::STAT_CHAR_W-1:0]};
      rsp_word.drive_enable = drv_in;
      rsp_word.drive_value  = drv_in ? drv_val_in : 4'd0;
      rsp_word.port_value   = port_in;
   end

   nrbs_store u_store (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .main_data   (main_data),
      .status_data (status_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         chip_pair_ff <= 2'd0;
         seen_sync_ff <= 1'b0;
         phase_ff     <= 4'd0;
         opcode_ff    <= 8'd0;
         sel_ff       <= 1'b0;
         reg_ff       <= '0;
         char_ff      <= 4'd0;
         port_ff      <= 4'd0;
         drv_ff       <= 1'b0;
         drv_val_ff   <= 4'd0;
         wr_ptr_ff    <= 1'b0;
         rd_ptr_ff    <= 1'b0;
         count_ff     <= 2'd0;
      end else begin
         if (csr_wr_en) chip_pair_ff <= csr_wr_data;
         seen_sync_ff <= seen_sync_in;
         phase_ff     <= phase_in;
         opcode_ff    <= opcode_in;
         sel_ff       <= sel_in;
         reg_ff       <= reg_in;
         char_ff      <= char_in;
         port_ff      <= port_in;
         drv_ff       <= drv_in;
         drv_val_ff   <= drv_val_in;
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) rsp_q_ff[wr_ptr_ff] <= rsp_word;
   end

   assign rsp_bus_drive_enable = rsp_q_ff[rd_ptr_ff].drive_enable;
   assign rsp_bus_drive_value  = rsp_q_ff[rd_ptr_ff].drive_value;
   assign rsp_port_value       = rsp_q_ff[rd_ptr_ff].port_value;

endmodule

FILE: sv/nrbs_store.sv
// Main and status nibble memories with valid bits and write bypass.
module nrbs_store (
   input  logic                          clock,
   input  logic                          reset,
   input  nrbs_pkg::store_ctl_type       ctl,
   output logic [3:0]                    main_data,
   output logic [3:0]                    status_data
);

   logic [3:0] main_mem   [nrbs_pkg::MAIN_DEPTH];
   logic [3:0] status_mem [nrbs_pkg::STAT_DEPTH];

   logic [nrbs_pkg::MAIN_AW-1:0]    main_addr_ff;
   logic [nrbs_pkg::STAT_AW-1:0]    status_addr_ff;
   logic [3:0]                      main_q_ff;
   logic [3:0]                      status_q_ff;
   logic [nrbs_pkg::MAIN_DEPTH-1:0] main_valid_ff, main_valid_in;
   logic [nrbs_pkg::STAT_DEPTH-1:0] status_valid_ff, status_valid_in;

   always_comb begin
      main_valid_in   = main_valid_ff;
      status_valid_in = status_valid_ff;
      if (ctl.clear) begin
         main_valid_in   = '0;
         status_valid_in = '0;
      end else begin
         if (ctl.main_we) main_valid_in[main_addr_ff] = 1'b1;
         if (ctl.status_we) status_valid_in[status_addr_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_addr_ff    <= '0;
         status_addr_ff  <= '0;
         main_valid_ff   <= '0;
         status_valid_ff <= '0;
      end else begin
         main_addr_ff    <= ctl.main_addr_in;
         status_addr_ff  <= ctl.status_addr_in;
         main_valid_ff   <= main_valid_in;
         status_valid_ff <= status_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.main_we) main_mem[main_addr_ff] <= ctl.wr_data;
      if (ctl.main_we && (main_addr_ff == ctl.main_addr_in)) begin
         main_q_ff <= ctl.wr_data;
      end else begin
         main_q_ff <= main_mem[ctl.main_addr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.status_we) status_mem[status_addr_ff] <= ctl.wr_data;
      if (ctl.status_we && (status_addr_ff == ctl.status_addr_in)) begin
         status_q_ff <= ctl.wr_data;
      end else begin
         status_q_ff <= status_mem[ctl.status_addr_in];
      end
   end

   assign main_data   = main_valid_ff[main_addr_ff] ? main_q_ff : 4'd0;
   assign status_data = status_valid_ff[status_addr_ff] ? status_q_ff : 4'd0;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the nibble RAM bus slave: bus-cycle stimulus, mirror model, checks.
module tb_top;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int         HOLD_CYCLES = 48;

   class ram_bus_mirror;
      logic [3:0]   ram_chars [nrbs_pkg::MAIN_DEPTH];
      logic [3:0]   ram_status [nrbs_pkg::STAT_DEPTH];
      logic [3:0]   port_q;
      logic [3:0]   char_sel;
      logic [3:0]   phase;
      logic [3:0]   drive_nib;
      logic [1:0]   reg_sel;
      logic [1:0]   pair;
      logic [7:0]   opcode;
      bit           selected;
      bit           synced;
      bit           driving;
      nrbs_pkg::rsp_word_type pending_words [$];
      int           errors;

      function new();
         pair      = 2'd0;
         drive_nib = 4'h0;
         errors    = 0;
         clear_pins();
      endfunction

      function void clear_pins();
         foreach (ram_chars[i]) ram_chars[i] = 4'h0;
         foreach (ram_status[i]) ram_status[i] = 4'h0;
         port_q   = 4'h0;
         reg_sel  = 2'd0;
         char_sel = 4'h0;
         selected = 1'b0;
         synced   = 1'b0;
         phase    = 4'd0;
         opcode   = 8'h00;
         driving  = 1'b0;
      endfunction

      function void advance_phase(logic [3:0] d, logic cm);
         logic [7:0] op;
         bit         is_src;
         op     = opcode;
         is_src = (op & nrbs_pkg::SRC_MASK) == nrbs_pkg::SRC_CODE;
         if (!synced) return;
         if (phase < nrbs_pkg::PHASE_MAX) phase++;
         case (phase)
            nrbs_pkg::PH_OPR: opcode = {d, 4'h0};
            nrbs_pkg::PH_OPA: opcode = opcode | {4'h0, d};
            nrbs_pkg::PH_READ: begin
               if (selected) begin
                  if (op == nrbs_pkg::OP_RDM || op == nrbs_pkg::OP_SBM ||
                      op == nrbs_pkg::OP_ADM) begin
                     driving   = 1'b1;
                     drive_nib = ram_chars[{reg_sel, char_sel}];
                  end else if (op >= nrbs_pkg::OP_RD0 && op <= nrbs_pkg::OP_RD3) begin
                     driving   = 1'b1;
                     drive_nib = ram_status[{reg_sel, op[1:0]}];
                  end
               end
            end
            nrbs_pkg::PH_WRITE: begin
               if (is_src) begin
                  if (cm) begin
                     selected = d[3:2] == pair;
                     if (selected) reg_sel = d[1:0];
                  end
               end else if (selected && cm) begin
                  if (op == nrbs_pkg::OP_WRM) begin
                     ram_chars[{reg_sel, char_sel}] = d;
                  end else if (op == nrbs_pkg::OP_WMP) begin
                     port_q = d;
                  end else if (op >= nrbs_pkg::OP_WR0 && op <= nrbs_pkg::OP_WR3) begin
                     ram_status[{reg_sel, op[1:0]}] = d;
                  end
               end
               driving = 1'b0;
            end
            nrbs_pkg::PH_CHAR: begin
               if (selected && is_src) char_sel = d;
            end
            default: ;
         endcase
      endfunction

      function void take_event(logic [1:0] m, logic [3:0] d, logic cm);
         nrbs_pkg::rsp_word_type w;
         case (m)
            nrbs_pkg::MODE_TICK: advance_phase(d, cm);
            nrbs_pkg::MODE_SYNC: begin
               synced = 1'b1;
               phase  = 4'd0;
               opcode = 8'h00;
            end
            nrbs_pkg::MODE_RESET: clear_pins();
            default: ;
         endcase
         w.drive_enable = driving;
         w.drive_value  = driving ? drive_nib : 4'h0;
         w.port_value   = port_q;
         pending_words.push_back(w);
      endfunction

      function void check_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         end
      endfunction

      function void compare_word(nrbs_pkg::rsp_word_type got);
         nrbs_pkg::rsp_word_type want;
         if (pending_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none actual %h", $time, got);
            return;
         end
         want = pending_words.pop_front();
         check_field("bus_drive_enable", want.drive_enable, got.drive_enable);
         check_field("bus_drive_value", want.drive_value, got.drive_value);
         check_field("port_value", want.port_value, got.port_value);
      endfunction

      function int outstanding();
         return pending_words.size();
      endfunction
   endclass

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       csr_wr_en      = 1'b0;
   logic [1:0] csr_wr_data    = 2'd0;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic [1:0] req_mode       = 2'd0;
   logic [3:0] req_bus_nibble = 4'h0;
   logic       req_chip_match = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   logic       rsp_bus_drive_enable;
   logic [3:0] rsp_bus_drive_value;
   logic [3:0] rsp_port_value;

   ram_bus_mirror mirror = new();
   int            sent_count = 0;
   int            burst_left = 0;
   logic [1:0]    cur_pair   = 2'd0;
   bit            long_hold  = 1'b0;

   nibble_ram_bus_slave_4002 uut (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_bus_nibble       (req_bus_nibble),
      .req_chip_match       (req_chip_match),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_bus_drive_enable (rsp_bus_drive_enable),
      .rsp_bus_drive_value  (rsp_bus_drive_value),
      .rsp_port_value       (rsp_port_value)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         mirror.compare_word({rsp_bus_drive_enable, rsp_bus_drive_value, rsp_port_value});
      end
   end

   initial begin : rsp_side
      int span;
      int style;
      int k;
      forever begin
         span  = $urandom_range(10, 60);
         style = $urandom_range(0, 2);
         for (k = 0; k < span; k++) begin
            @(posedge clock);
            if (long_hold) begin
               rsp_ready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
               long_hold = 1'b0;
            end
            case (style)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= (k % 3) == 0;
            endcase
         end
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   task automatic offer(input logic [1:0] m, input logic [3:0] d, input logic cm);
      req_valid      <= 1'b1;
      req_mode       <= m;
      req_bus_nibble <= d;
      req_chip_match <= cm;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      mirror.take_event(m, d, cm);
      sent_count++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic pause_until_empty();
      req_valid <= 1'b0;
      @(posedge clock);
      while (mirror.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_pair(input logic [1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      mirror.pair  = v;
      cur_pair     = v;
   endtask

   task automatic bus_cycle(input logic [3:0] hi, input logic [3:0] lo, input logic [3:0] d7,
                            input logic cm7, input logic [3:0] d8, input int ticks);
      int         t;
      logic [3:0] d;
      logic       c;
      offer(nrbs_pkg::MODE_SYNC, 4'($urandom), 1'($urandom));
      for (t = 1; t <= ticks; t++) begin
         d = 4'($urandom);
         c = 1'($urandom);
         if (t == nrbs_pkg::PH_OPR) begin
            d = hi;
         end else if (t == nrbs_pkg::PH_OPA) begin
            d = lo;
         end else if (t == nrbs_pkg::PH_WRITE) begin
            d = d7;
            c = cm7;
         end else if (t == nrbs_pkg::PH_CHAR) begin
            d = d8;
         end
         offer(nrbs_pkg::MODE_TICK, d, c);
      end
   endtask

   task automatic random_cycle();
      logic [7:0] op;
      logic [3:0] d7;
      logic [1:0] m;
      int         k;
      int         n;
      k = $urandom_range(0, 19);
      if (k < 3) begin
         k = $urandom_range(0, 19);
         m = (k < 8)  ? nrbs_pkg::MODE_TICK :
             (k < 12) ? nrbs_pkg::MODE_SYNC :
             (k < 17) ? MODE_UNUSED : nrbs_pkg::MODE_RESET;
         offer(m, 4'($urandom), 1'($urandom));
         return;
      end
      case ($urandom_range(0, 9))
         0, 1, 2: op = nrbs_pkg::SRC_CODE | {4'h0, 3'($urandom), 1'b0};
         3, 4: begin
            k  = $urandom_range(0, 5);
            op = (k == 0) ? nrbs_pkg::OP_WRM : (k == 1) ? nrbs_pkg::OP_WMP
                                                        : nrbs_pkg::OP_WR0 + 8'(k - 2);
         end
         5, 6, 7: begin
            k  = $urandom_range(0, 6);
            op = (k == 0) ? nrbs_pkg::OP_RDM : (k == 1) ? nrbs_pkg::OP_SBM :
                 (k == 2) ? nrbs_pkg::OP_ADM : nrbs_pkg::OP_RD0 + 8'(k - 3);
         end
         default: op = 8'($urandom);
      endcase
      d7 = 4'($urandom);
      if ((op & nrbs_pkg::SRC_MASK) == nrbs_pkg::SRC_CODE && $urandom_range(0, 3) != 0)
         d7[3:2] = cur_pair;
      k = $urandom_range(0, 9);
      n = (k < 6) ? 8 : (k < 8) ? $urandom_range(9, 12) : $urandom_range(1, 7);
      bus_cycle(op[7:4], op[3:0], d7, $urandom_range(0, 7) != 0, 4'($urandom), n);
   endtask

   initial begin : stimulus
      logic [1:0] pair_plan [4];
      int         p;
      int         goal;
      bit         held;
      bit         paused;
      pair_plan = '{2'd3, 2'd1, 2'd2, 2'd0};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      write_pair(2'd0);

      offer(nrbs_pkg::MODE_TICK, 4'hF, 1'b1);
      offer(MODE_UNUSED, 4'hF, 1'b1);
      bus_cycle(nrbs_pkg::SRC_CODE[7:4], nrbs_pkg::SRC_CODE[3:0], 4'b0011, 1'b1, 4'hF, 10);
      bus_cycle(nrbs_pkg::OP_WRM[7:4], nrbs_pkg::OP_WRM[3:0], 4'hF, 1'b1, 4'h0, 7);
      bus_cycle(nrbs_pkg::OP_RDM[7:4], nrbs_pkg::OP_RDM[3:0], 4'h0, 1'b0, 4'h0, 6);
      offer(nrbs_pkg::MODE_RESET, 4'h0, 1'b0);

      for (p = 0; p < 4; p++) begin
         pause_until_empty();
         write_pair(pair_plan[p]);
         goal   = sent_count + 160;
         held   = 1'b0;
         paused = 1'b0;
         while (sent_count < goal) begin
            if (!held && sent_count > goal - 110) begin
               held      = 1'b1;
               long_hold = 1'b1;
            end
            if (!paused && sent_count > goal - 50) begin
               paused = 1'b1;
               pause_until_empty();
            end
            random_cycle();
         end
      end

      pause_until_empty();
      repeat (20) @(posedge clock);
      if (mirror.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

FILE: sim.f
sv/nrbs_pkg.sv
sv/nrbs_store.sv
sv/nibble_ram_bus_slave_4002.sv
test/tb_top.sv
